/* rtl/yiq_chroma_noise_pixel_top_macros.svh */
// Assertion macros for the chroma noise pixel block.
// Needs clk and rst in the scope where a macro is used.
`ifndef YIQ_CHROMA_NOISE_PIXEL_TOP_MACROS_SVH
`define YIQ_CHROMA_NOISE_PIXEL_TOP_MACROS_SVH

// same-cycle implication
`define YCN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define YCN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ycn_pkg.sv */
// Shared types, constants and arithmetic helpers for the chroma noise pixel block.
// No dependencies.
package ycn_pkg;

  localparam int NSTG = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN   = 2'd1;

  localparam logic [7:0] CHROMA_GAIN_RST = 8'd56;
  localparam logic [7:0] LUMA_GAIN_RST   = 8'd19;

  // reciprocal constants, ceil(2^DIV_SH / d), exact for numerators below 2^15
  localparam int DIV_SH = 25;
  localparam logic [20:0] RCP_31  = 21'((2**DIV_SH + 31 - 1) / 31);
  localparam logic [20:0] RCP_63  = 21'((2**DIV_SH + 63 - 1) / 63);
  localparam logic [20:0] RCP_223 = 21'((2**DIV_SH + 223 - 1) / 223);
  localparam logic [20:0] RCP_391 = 21'((2**DIV_SH + 391 - 1) / 391);
  localparam logic [20:0] RCP_783 = 21'((2**DIV_SH + 783 - 1) / 783);
  localparam logic [20:0] RCP_375 = 21'((2**DIV_SH + 375 - 1) / 375);
  localparam logic [20:0] RCP_192 = 21'((2**DIV_SH + 192 - 1) / 192);
  localparam logic [20:0] RCP_143 = 21'((2**DIV_SH + 143 - 1) / 143);

  typedef struct packed {
    logic [NSTG-1:0] load;
  } pipe_ctl_t;

  typedef struct packed {
    logic [7:0] chroma;
    logic [7:0] luma;
  } gain_t;

  typedef struct packed {
    logic              apply;
    logic [15:0]       px;
    logic [7:0]        y;
    logic signed [7:0] i;
    logic signed [7:0] q;
  } yiq_t;

  function automatic logic [7:0] rdiv(input logic [14:0] x, input logic [20:0] m);
    logic [35:0] p;
    p = 36'(x) * 36'(m);
    return p[DIV_SH+7:DIV_SH];
  endfunction

  // signed divide by 256, truncating toward zero
  function automatic logic signed [8:0] noise_div(input logic signed [17:0] p);
    logic signed [17:0] t;
    t = p + (p[17] ? 18'sd255 : 18'sd0);
    return t[16:8];
  endfunction

  function automatic logic [7:0] clamp_u8(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 12'sd0) r = 8'd0;
    else if (v > 12'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic logic signed [7:0] clamp_s8(input logic signed [11:0] v);
    logic signed [7:0] r;
    if (v < -12'sd127) r = -8'sd127;
    else if (v > 12'sd127) r = 8'sd127;
    else r = v[7:0];
    return r;
  endfunction

endpackage

/* rtl/ycn_cfg.sv */
// Gain registers written through the plain configuration port.
// Depends on ycn_pkg.
module ycn_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ycn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output ycn_pkg::gain_t                 gains
);
  import ycn_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.chroma <= CHROMA_GAIN_RST;
      gains.luma   <= LUMA_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHROMA_GAIN: gains.chroma <= cfg_data;
        REG_LUMA_GAIN:   gains.luma   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ycn_ctrl.sv */
// Valid bits and per-stage load enables of the pixel pipeline.
// Depends on ycn_pkg and the assertion macro header.
`include "yiq_chroma_noise_pixel_top_macros.svh"

module ycn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_stall,
  output logic                in_stall,
  output logic                out_valid,
  output ycn_pkg::pipe_ctl_t  pctl
);
  import ycn_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] load;

  // a stage loads when empty or when its content moves on
  always_comb begin
    load[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pctl.load = load;
  assign in_stall  = !load[0];
  assign out_valid = vld[NSTG-1];

  `YCN_ASSERT_NXT(a_take_lands, in_valid && !in_stall, vld[0], "transfer lost at stage one")
  `YCN_ASSERT_IMP(a_full_stalls, (&vld) && out_stall, in_stall, "input taken while full")
  `YCN_ASSERT_NXT(a_last_moves, vld[NSTG-2] && load[NSTG-1], out_valid, "item lost at output")

endmodule

/* rtl/ycn_to_yiq.sv */
// Stages one to three: RGB565 unpack, YIQ conversion, noise add and clamps.
// Depends on ycn_pkg.
module ycn_to_yiq (
  input  logic               clk,
  input  ycn_pkg::pipe_ctl_t pctl,
  input  ycn_pkg::gain_t     gains,
  input  logic [15:0]        pixel_in,
  input  logic               apply_noise,
  input  logic [7:0]         rand_luma,
  input  logic [7:0]         rand_in_phase,
  input  logic [7:0]         rand_quadrature,
  output ycn_pkg::yiq_t      yiq
);
  import ycn_pkg::*;

  logic [15:0]        pxu;
  logic [4:0]         r5;
  logic [5:0]         g6;
  logic [4:0]         b5;
  logic signed [9:0]  dl, di, dq;
  logic signed [8:0]  lg, cg;
  logic signed [17:0] pl, pi, pq;

  logic               s1_apply;
  logic [15:0]        s1_px;
  logic [13:0]        s1_yr, s1_yg, s1_yb, s1_ig, s1_ib, s1_qr, s1_qg, s1_qb;
  logic signed [17:0] s1_pl, s1_pi, s1_pq;

  logic               s2_apply;
  logic [15:0]        s2_px;
  logic [7:0]         s2_yr, s2_yg, s2_yb, s2_ig, s2_ib, s2_qr, s2_qg, s2_qb;
  logic signed [8:0]  s2_nl, s2_ni, s2_nq;

  logic [9:0]         ysum;
  logic signed [11:0] isum, qsum, yw, iw, qw;
  logic [7:0]         yc;
  logic signed [7:0]  ic, qc;
  yiq_t               yiq_next;

  // stage one: unswap, numerators, noise products
  always_comb begin
    pxu = {pixel_in[7:0], pixel_in[15:8]};
    r5  = pxu[15:11];
    g6  = pxu[10:5];
    b5  = pxu[4:0];
    lg  = $signed({1'b0, gains.luma});
    cg  = $signed({1'b0, gains.chroma});
    dl  = $signed({2'b00, rand_luma}) - 10'sd32;
    di  = $signed({2'b00, rand_in_phase}) - 10'sd128;
    dq  = $signed({2'b00, rand_quadrature}) - 10'sd128;
    pl  = dl * lg;
    pi  = di * cg;
    pq  = dq * cg;
  end

  always_ff @(posedge clk) begin
    if (pctl.load[0]) begin
      s1_apply <= apply_noise;
      s1_px    <= pixel_in;
      s1_yr    <= 14'(r5) * 14'd76;
      s1_yg    <= 14'(g6) * 14'd150;
      s1_yb    <= 14'(b5) * 14'd37;
      s1_ig    <= 14'(g6) * 14'd35;
      s1_ib    <= 14'(b5) * 14'd41;
      s1_qr    <= 14'(r5) * 14'd27;
      s1_qg    <= 14'(g6) * 14'd66;
      s1_qb    <= 14'(b5) * 14'd40;
      s1_pl    <= pl;
      s1_pi    <= pi;
      s1_pq    <= pq;
    end
  end

  // stage two: constant divides, noise scaling
  always_ff @(posedge clk) begin
    if (pctl.load[1]) begin
      s2_apply <= s1_apply;
      s2_px    <= s1_px;
      s2_yr    <= rdiv(15'(s1_yr), RCP_31);
      s2_yg    <= rdiv(15'(s1_yg), RCP_63);
      s2_yb    <= rdiv(15'(s1_yb), RCP_31);
      s2_ig    <= rdiv(15'(s1_ig), RCP_63);
      s2_ib    <= rdiv(15'(s1_ib), RCP_31);
      s2_qr    <= rdiv(15'(s1_qr), RCP_31);
      s2_qg    <= rdiv(15'(s1_qg), RCP_63);
      s2_qb    <= rdiv(15'(s1_qb), RCP_31);
      s2_nl    <= noise_div(s1_pl);
      s2_ni    <= noise_div(s1_pi);
      s2_nq    <= noise_div(s1_pq);
    end
  end

  // stage three: sums, clamp, noise, clamp
  always_comb begin
    ysum = 10'(s2_yr) + 10'(s2_yg) + 10'(s2_yb);
    isum = $signed({4'b0, s2_yr}) - $signed({4'b0, s2_ig}) - $signed({4'b0, s2_ib});
    qsum = $signed({4'b0, s2_qr}) - $signed({4'b0, s2_qg}) + $signed({4'b0, s2_qb});
    yc   = clamp_u8($signed({2'b00, ysum}));
    ic   = clamp_s8(isum);
    qc   = clamp_s8(qsum);
    yw   = $signed({4'b0, yc}) + 12'(s2_nl);
    iw   = 12'(ic) + 12'(s2_ni);
    qw   = 12'(qc) + 12'(s2_nq);
    yiq_next.apply = s2_apply;
    yiq_next.px    = s2_px;
    yiq_next.y     = clamp_u8(yw);
    yiq_next.i     = clamp_s8(iw);
    yiq_next.q     = clamp_s8(qw);
  end

  always_ff @(posedge clk) begin
    if (pctl.load[2]) yiq <= yiq_next;
  end

endmodule

/* rtl/ycn_to_rgb.sv */
// Stages four and five: YIQ back to RGB, clamp, RGB565 pack and byte swap.
// Depends on ycn_pkg.
module ycn_to_rgb (
  input  logic               clk,
  input  ycn_pkg::pipe_ctl_t pctl,
  input  ycn_pkg::yiq_t      yiq,
  output logic [15:0]        pixel_out
);
  import ycn_pkg::*;

  logic [7:0]  ai_w, aq_w;
  logic [14:0] ni, nq;

  logic        s4_apply;
  logic [15:0] s4_px;
  logic [7:0]  s4_y;
  logic        s4_si, s4_sq;
  logic [7:0]  s4_ri, s4_rq, s4_gi, s4_gq, s4_bi, s4_bq;

  logic signed [11:0] rw, gw, bw;
  logic [7:0]         ro, go, bo;
  logic [15:0]        pk;
  logic [15:0]        pixel_next;

  function automatic logic signed [11:0] sgn(input logic s, input logic [7:0] m);
    logic signed [11:0] v;
    v = $signed({4'b0, m});
    return s ? -v : v;
  endfunction

  // stage four: magnitudes times 255, constant divides
  always_comb begin
    ai_w = yiq.i[7] ? 8'(-yiq.i) : 8'(yiq.i);
    aq_w = yiq.q[7] ? 8'(-yiq.q) : 8'(yiq.q);
    ni   = {ai_w[6:0], 8'b0} - {8'b0, ai_w[6:0]};
    nq   = {aq_w[6:0], 8'b0} - {8'b0, aq_w[6:0]};
  end

  always_ff @(posedge clk) begin
    if (pctl.load[3]) begin
      s4_apply <= yiq.apply;
      s4_px    <= yiq.px;
      s4_y     <= yiq.y;
      s4_si    <= yiq.i[7];
      s4_sq    <= yiq.q[7];
      s4_ri    <= rdiv(ni, RCP_223);
      s4_rq    <= rdiv(nq, RCP_391);
      s4_gi    <= rdiv(ni, RCP_783);
      s4_gq    <= rdiv(nq, RCP_375);
      s4_bi    <= rdiv(ni, RCP_192);
      s4_bq    <= rdiv(nq, RCP_143);
    end
  end

  // stage five: sums, clamp, pack, swap
  always_comb begin
    rw = $signed({4'b0, s4_y}) + sgn(s4_si, s4_ri) + sgn(s4_sq, s4_rq);
    gw = $signed({4'b0, s4_y}) - sgn(s4_si, s4_gi) - sgn(s4_sq, s4_gq);
    bw = $signed({4'b0, s4_y}) - sgn(s4_si, s4_bi) + sgn(s4_sq, s4_bq);
    ro = clamp_u8(rw);
    go = clamp_u8(gw);
    bo = clamp_u8(bw);
    pk = {ro[7:3], go[7:2], bo[7:3]};
    pixel_next = s4_apply ? {pk[7:0], pk[15:8]} : s4_px;
  end

  always_ff @(posedge clk) begin
    if (pctl.load[4]) pixel_out <= pixel_next;
  end

endmodule

/* rtl/yiq_chroma_noise_pixel_top.sv */
// Channel      Signals                                              Dir
// pixel in     in_valid in_stall pixel_in apply_noise rand_*       in
// pixel out    out_valid out_stall pixel_out                        out
// config       cfg_we cfg_index cfg_data                            in
//
// Five register stages; one pixel per clock while in_stall is low. out_valid rises
// once the input transfer has reached the fifth stage register. Each stage holds
// its item while the next one is full, so bubbles close up under out_stall and
// in_stall rises only when all five are full and out_stall is high.
// rst clears the valid bits and sets the gains to 56 (chroma) and 19 (luma).
// Top level; depends on ycn_pkg, ycn_cfg, ycn_ctrl, ycn_to_yiq, ycn_to_rgb.
module yiq_chroma_noise_pixel_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    pixel_in,
  input  logic                           apply_noise,
  input  logic [7:0]                     rand_luma,
  input  logic [7:0]                     rand_in_phase,
  input  logic [7:0]                     rand_quadrature,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    pixel_out,
  input  logic                           cfg_we,
  input  logic [ycn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import ycn_pkg::*;

  gain_t     gains;
  pipe_ctl_t pctl;
  yiq_t      yiq;

  ycn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  ycn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .pctl      (pctl)
  );

  ycn_to_yiq u_to_yiq (
    .clk             (clk),
    .pctl            (pctl),
    .gains           (gains),
    .pixel_in        (pixel_in),
    .apply_noise     (apply_noise),
    .rand_luma       (rand_luma),
    .rand_in_phase   (rand_in_phase),
    .rand_quadrature (rand_quadrature),
    .yiq             (yiq)
  );

  ycn_to_rgb u_to_rgb (
    .clk       (clk),
    .pctl      (pctl),
    .yiq       (yiq),
    .pixel_out (pixel_out)
  );

endmodule
